// ----- sv/calendar_clock_second_tick_assert.svh -----
// Assertion macros for the calendar clock block.
// CCST_ASSERT checks a property while reset is low.
// CCST_ASSERT_RST checks a property at every edge, reset included.
`ifndef CALENDAR_CLOCK_SECOND_TICK_ASSERT_SVH
`define CALENDAR_CLOCK_SECOND_TICK_ASSERT_SVH
`ifndef SYNTH
`define CCST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("calendar clock assertion failed");
`define CCST_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("calendar clock reset assertion failed");
`else
`define CCST_ASSERT(label, clk, rst, prop)
`define CCST_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- sv/ccst_pkg.sv -----
`default_nettype none

package ccst_pkg;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [5:0]  SEC_MAX    = 6'd59;
   localparam logic [5:0]  MIN_MAX    = 6'd59;
   localparam logic [4:0]  HOUR_MAX   = 5'd23;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;
   localparam logic [15:0] YEAR_RESET = 16'd2018;

   // Multiplicative inverse of 25 modulo 2^16, and the largest product that
   // marks a multiple of 25 (floor(65535 / 25)).
   localparam logic [15:0] INV25       = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT = 16'd2621;

   typedef struct packed {
      logic        opcode;
      logic [5:0]  set_second;
      logic [5:0]  set_minute;
      logic [4:0]  set_hour;
      logic [4:0]  set_day;
      logic [3:0]  set_month;
      logic [15:0] set_year;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  now_second;
      logic [5:0]  now_minute;
      logic [4:0]  now_hour;
      logic [4:0]  now_day;
      logic [3:0]  now_month;
      logic [15:0] now_year;
   } rsp_word_type;

   // Days in a month; months without a defined length count as 31.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      unique case (month)
         4'd2:                      days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// ----- sv/ccst_if.sv -----
`default_nettype none

interface ccst_req_if import ccst_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface ccst_rsp_if import ccst_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// ----- sv/calendar_clock_second_tick.sv -----
// Calendar clock: seconds, minutes, hours, day, month and a 16-bit year.
// Request words arrive on req_chan. A word with opcode tick advances the
// clock by one second, with carries through the Gregorian calendar; a word
// with opcode load replaces every field with the set values as given.
// Every request word produces exactly one response word on rsp_chan that
// holds the date and time after that request.
// A request word is registered in the input register when it is accepted and
// applied to the clock registers once the clock stage may advance, so its
// response is then valid in the clock registers.
// One word per cycle is sustained when not stalled: the carry chain and
// the leap test (one 16-bit multiply by a constant) sit between the input
// register and the clock registers, which double as the response register.
// When the receiver stalls, the response holds and the input register still
// takes one more word; then req_chan.ready drops until the response is taken.
// Synchronous reset empties both stages and sets the clock to midnight,
// January 1, 2018.
`default_nettype none

module calendar_clock_second_tick import ccst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ccst_req_if.sink         req_chan,
   ccst_rsp_if.source       rsp_chan
);

`include "calendar_clock_second_tick_assert.svh"

   // Input stage.
   logic         in_vld_ff;
   logic         in_vld_in;
   req_word_type in_ff;
   req_word_type in_in;

   // Clock state, which is also the response payload.
   logic         out_vld_ff;
   logic         out_vld_in;
   rsp_word_type now_ff;
   rsp_word_type now_in;

   rsp_word_type step_word;
   logic         leap;
   logic         advance;
   logic         step;

   // The clock stage may take a new word when its response is gone or
   // leaving in this cycle.
   assign advance = !out_vld_ff || rsp_chan.ready;
   assign step    = in_vld_ff && advance;

   assign req_chan.ready = !in_vld_ff || advance;

   ccst_leap u_leap (
      .year (now_ff.now_year),
      .leap (leap)
   );

   ccst_step u_step (
      .cur  (now_ff),
      .req  (in_ff),
      .leap (leap),
      .nxt  (step_word)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_chan.ready) begin
         in_vld_in = req_chan.valid;
         in_in     = req_chan.word;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      now_in     = now_ff;
      if (advance) begin
         out_vld_in = in_vld_ff;
      end
      if (step) begin
         now_in = step_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         out_vld_ff        <= 1'b0;
         now_ff.now_second <= 6'd0;
         now_ff.now_minute <= 6'd0;
         now_ff.now_hour   <= 5'd0;
         now_ff.now_day    <= 5'd1;
         now_ff.now_month  <= 4'd1;
         now_ff.now_year   <= YEAR_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         now_ff     <= now_in;
      end
   end

   // The payload register needs no reset; only its valid flag does.
   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.word  = now_ff;

   // Reset leaves no response pending and the year at its starting value.
   `CCST_ASSERT_RST(a_reset_state, clock,
      reset |=> (!out_vld_ff && !in_vld_ff && (now_ff.now_year == YEAR_RESET)))

   // Every applied request word produces a pending response next cycle.
   `CCST_ASSERT(a_step_valid, clock, reset, step |=> out_vld_ff)

   // A load step stores the set second, day and year unchanged.
   `CCST_ASSERT(a_load_fields, clock, reset,
      (step && (in_ff.opcode == OP_LOAD)) |=>
         ((now_ff.now_second == $past(in_ff.set_second)) &&
          (now_ff.now_year == $past(in_ff.set_year)) &&
          (now_ff.now_day == $past(in_ff.set_day))))

   // A tick step advances the seconds, wrapping anything at or past the limit.
   `CCST_ASSERT(a_tick_second, clock, reset,
      (step && (in_ff.opcode == OP_TICK)) |=>
         (now_ff.now_second == (($past(now_ff.now_second) >= SEC_MAX) ? 6'd0 :
                                ($past(now_ff.now_second) + 6'd1))))

   // Without a step, the clock does not move.
   `CCST_ASSERT(a_hold_state, clock, reset, !step |=> $stable(now_ff))

endmodule

`default_nettype wire

// ----- sv/ccst_leap.sv -----
`default_nettype none

module ccst_leap import ccst_pkg::*; (
   input  logic [15:0] year,
   output logic        leap
);

   logic [15:0] prod_lo;
   logic        div25;

   // Multiplying by the inverse of 25 maps multiples of 25 onto 0..2621.
   assign prod_lo = year * INV25;
   assign div25   = (prod_lo <= DIV25_LIMIT);

   assign leap = ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);

endmodule

`default_nettype wire

// ----- sv/ccst_step.sv -----
`default_nettype none

module ccst_step import ccst_pkg::*; (
   input  rsp_word_type cur,
   input  req_word_type req,
   input  logic         leap,
   output rsp_word_type nxt
);

   logic [6:0] sec_sum;
   logic [6:0] min_sum;
   logic [5:0] hour_sum;
   logic [5:0] day_sum;
   logic [4:0] month_sum;
   logic       sec_wrap;
   logic       min_wrap;
   logic       hour_wrap;
   logic       day_wrap;
   logic       month_wrap;
   logic [4:0] day_limit;

   // A field that is past its limit after the carry in goes to its low end and
   // carries, which also cleans up out-of-range loaded values.
   assign sec_sum   = {1'b0, cur.now_second} + 7'd1;
   assign sec_wrap  = sec_sum > {1'b0, SEC_MAX};
   assign min_sum   = {1'b0, cur.now_minute} + {6'd0, sec_wrap};
   assign min_wrap  = min_sum > {1'b0, MIN_MAX};
   assign hour_sum  = {1'b0, cur.now_hour} + {5'd0, min_wrap};
   assign hour_wrap = hour_sum > {1'b0, HOUR_MAX};
   assign day_limit = month_days(cur.now_month, leap);
   assign day_sum   = {1'b0, cur.now_day} + {5'd0, hour_wrap};
   assign day_wrap  = day_sum > {1'b0, day_limit};
   assign month_sum = {1'b0, cur.now_month} + {4'd0, day_wrap};
   assign month_wrap = month_sum > {1'b0, MONTH_MAX};

   always_comb begin
      if (req.opcode == OP_LOAD) begin
         nxt.now_second = req.set_second;
         nxt.now_minute = req.set_minute;
         nxt.now_hour   = req.set_hour;
         nxt.now_day    = req.set_day;
         nxt.now_month  = req.set_month;
         nxt.now_year   = req.set_year;
      end else begin
         nxt.now_second = sec_wrap ? 6'd0 : sec_sum[5:0];
         nxt.now_minute = min_wrap ? 6'd0 : min_sum[5:0];
         nxt.now_hour   = hour_wrap ? 5'd0 : hour_sum[4:0];
         nxt.now_day    = day_wrap ? 5'd1 : day_sum[4:0];
         nxt.now_month  = month_wrap ? 4'd1 : month_sum[3:0];
         nxt.now_year   = cur.now_year + {15'd0, month_wrap};
      end
   end

endmodule

`default_nettype wire

// ----- sim/calendar_clock_second_tick_tb.sv -----
module calendar_clock_second_tick_tb import ccst_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Number of request words in the random part of the run.
   localparam int unsigned RANDOM_WORDS = 1950;
   // Only this many mismatch lines are printed; all of them are counted.
   localparam int unsigned PRINT_LIMIT = 40;

   logic clock;
   logic reset;

   ccst_req_if req_chan ();
   ccst_rsp_if rsp_chan ();

   calendar_clock_second_tick DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The testbench's own copy of the clock registers, advanced once for
   // every request word that the block accepts.
   rsp_word_type calendar_now;
   // Date and time words still owed by the block, oldest first.
   rsp_word_type pending_times[$];

   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   // When set, the sender or the receiver runs without any idle cycles.
   bit send_steady = 1'b0;
   bit rsp_steady = 1'b0;

   // The clock starts low, so the first rising edge comes at 5 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Gregorian month length. Months without a defined length count as 31.
   function automatic int unsigned days_in_month(input logic [3:0] month,
                                                 input logic [15:0] year);
      bit leap;
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      case (month)
         4'd2: begin
            return leap ? 29 : 28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // Works out the date and time after one request word. A load stores the
   // set fields exactly as given. A tick adds one second and ripples the
   // carry upward; any field found beyond its limit after its carry in is
   // wrapped and passes a carry on, even if no carry came into it, so a
   // loaded value that is too large rolls over on the very next tick.
   function automatic rsp_word_type next_calendar(input rsp_word_type cur,
                                                  input req_word_type w);
      rsp_word_type nxt;
      int unsigned v;
      int unsigned carry;
      if (w.opcode == OP_LOAD) begin
         nxt.now_second = w.set_second;
         nxt.now_minute = w.set_minute;
         nxt.now_hour   = w.set_hour;
         nxt.now_day    = w.set_day;
         nxt.now_month  = w.set_month;
         nxt.now_year   = w.set_year;
      end else begin
         v = cur.now_second + 1;
         carry = 0;
         if (v > SEC_MAX) begin
            v = 0;
            carry = 1;
         end
         nxt.now_second = 6'(v);

         v = cur.now_minute + carry;
         carry = 0;
         if (v > MIN_MAX) begin
            v = 0;
            carry = 1;
         end
         nxt.now_minute = 6'(v);

         v = cur.now_hour + carry;
         carry = 0;
         if (v > HOUR_MAX) begin
            v = 0;
            carry = 1;
         end
         nxt.now_hour = 5'(v);

         // The month length comes from the month and year before this tick.
         // A day of zero is not repaired here; it only moves when a carry
         // comes in.
         v = cur.now_day + carry;
         carry = 0;
         if (v > days_in_month(cur.now_month, cur.now_year)) begin
            v = 1;
            carry = 1;
         end
         nxt.now_day = 5'(v);

         // Months 13 to 15 always wrap to January; month zero holds until a
         // day carry lifts it to one.
         v = cur.now_month + carry;
         carry = 0;
         if (v > MONTH_MAX) begin
            v = 1;
            carry = 1;
         end
         nxt.now_month = 4'(v);

         nxt.now_year = 16'(cur.now_year + carry);
      end
      return nxt;
   endfunction

   // Mostly no idle time, often a short gap, now and then a long one.
   function automatic int unsigned idle_cycles();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type random_word();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[$bits(req_word_type)-1:0];
   endfunction

   // A tick word carries random set fields, which the block must ignore.
   function automatic req_word_type tick_word();
      req_word_type w;
      w = random_word();
      w.opcode = OP_TICK;
      return w;
   endfunction

   function automatic req_word_type load_word(input int unsigned second,
                                              input int unsigned minute,
                                              input int unsigned hour,
                                              input int unsigned day,
                                              input int unsigned month,
                                              input int unsigned year);
      req_word_type w;
      w.opcode     = OP_LOAD;
      w.set_second = 6'(second);
      w.set_minute = 6'(minute);
      w.set_hour   = 5'(hour);
      w.set_day    = 5'(day);
      w.set_month  = 4'(month);
      w.set_year   = 16'(year);
      return w;
   endfunction

   // A valid date that sits close to a rollover, so that a short run of
   // ticks carries through minutes, hours, days, months and years. The year
   // is often a multiple of 4, 100 or 400, or the last year before the wrap.
   function automatic req_word_type calendar_edge_load();
      logic [15:0] year;
      logic [3:0] month;
      int unsigned length;
      int unsigned day;
      case ($urandom_range(5))
         0: year = 16'($urandom_range(163) * 400);
         1: year = 16'($urandom_range(655) * 100);
         2: year = 16'($urandom_range(16383) * 4);
         3: year = 16'hFFFF;
         default: year = 16'($urandom());
      endcase
      month = 4'($urandom_range(1, 12));
      length = days_in_month(month, year);
      if ($urandom_range(2) != 0) begin
         day = length - $urandom_range(0, 1);
      end else begin
         day = $urandom_range(1, length);
      end
      return load_word(($urandom_range(3) != 0) ? $urandom_range(40, 59)
                                                : $urandom_range(0, 59),
                       ($urandom_range(2) != 0) ? MIN_MAX : $urandom_range(0, 59),
                       ($urandom_range(2) != 0) ? HOUR_MAX : $urandom_range(0, 23),
                       day, month, year);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0d ns mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Drives one request word at a falling edge, after an optional idle gap,
   // and holds it until a rising edge finds ready high. The expected date
   // and time are worked out at that accepting edge. Valid is left high so
   // that a following word can go out without a bubble; whoever stops
   // sending lowers it at the next falling edge.
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      gap = send_steady ? 0 : idle_cycles();
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.word = w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      calendar_now = next_calendar(calendar_now, w);
      pending_times.push_back(calendar_now);
      words_sent++;
   endtask

   // Stops sending and waits until every owed response word has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_times.size() != 0) @(posedge clock);
   endtask

   // The first ticks after reset count up from midnight, January 1, 2018.
   task automatic test_reset_state();
      repeat (3) send_word(tick_word());
   endtask

   // Loads followed by one tick each, aimed at every rollover and at the
   // out-of-range values that a load may store.
   task automatic test_directed_edges();
      // All fields zero: the day and month of zero are kept by a tick.
      send_word(load_word(0, 0, 0, 0, 0, 0));
      send_word(tick_word());
      // Month zero moves to January only on a day carry.
      send_word(load_word(59, 59, 23, 31, 0, 0));
      send_word(tick_word());
      // Every field at its largest encoding: everything wraps at once.
      send_word(load_word(63, 63, 31, 31, 15, 65535));
      send_word(tick_word());
      // New Year's Eve of the last year wraps the year to zero.
      send_word(load_word(59, 59, 23, 31, 12, 65535));
      send_word(tick_word());
      // Leap day of a year divisible by 400 rolls into March.
      send_word(load_word(59, 59, 23, 29, 2, 2000));
      send_word(tick_word());
      // A century year that is not a leap year has no February 29.
      send_word(load_word(59, 59, 23, 28, 2, 1900));
      send_word(tick_word());
      // An ordinary leap year does have a February 29.
      send_word(load_word(59, 59, 23, 28, 2, 2024));
      send_word(tick_word());
      // End of a thirty-day month.
      send_word(load_word(59, 59, 23, 30, 4, 2021));
      send_word(tick_word());
      // A day loaded beyond the month length rolls over with no carry in.
      send_word(load_word(0, 0, 0, 31, 4, 2021));
      send_word(tick_word());
      // Seconds, minutes and hours loaded beyond their limits.
      send_word(load_word(62, 62, 27, 5, 7, 2030));
      send_word(tick_word());
   endtask

   // The sender holds off until the block has nothing left to deliver,
   // then resumes with the receiver stalling on its own schedule.
   task automatic test_drain_pause();
      send_word(calendar_edge_load());
      repeat (12) send_word(tick_word());
      wait_drained();
      repeat (12) send_word(tick_word());
   endtask

   // Mostly a boundary date followed by a run of ticks; some loads with
   // fully random bits, some runs of ticks alone. Each segment picks anew
   // whether either side runs without idle cycles.
   task automatic test_random_calendar();
      int unsigned start_count;
      int unsigned run;
      int unsigned pick;
      req_word_type w;
      start_count = words_sent;
      while (words_sent - start_count < RANDOM_WORDS) begin
         send_steady = ($urandom_range(5) == 0);
         rsp_steady = ($urandom_range(5) == 0);
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_word(calendar_edge_load());
            run = $urandom_range(1, 40);
         end else if (pick < 92) begin
            w = random_word();
            w.opcode = OP_LOAD;
            send_word(w);
            run = $urandom_range(1, 8);
         end else begin
            run = $urandom_range(1, 10);
         end
         repeat (run) send_word(tick_word());
         if ($urandom_range(29) == 0) begin
            wait_drained();
         end
      end
      send_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // The receiver alternates between stretches of ready and stretches of
   // stall, each decided at a falling edge.
   always begin
      int unsigned hold;
      @(negedge clock);
      if (rsp_steady) begin
         rsp_chan.ready = 1'b1;
         hold = 1;
      end else if ($urandom_range(2) != 0) begin
         rsp_chan.ready = 1'b1;
         hold = $urandom_range(1, 6);
      end else begin
         rsp_chan.ready = 1'b0;
         hold = idle_cycles() + 1;
      end
      repeat (hold - 1) @(negedge clock);
   end

   // Every response word taken at a rising edge is compared, field by
   // field, with the oldest date and time still owed.
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = rsp_chan.word;
         if (pending_times.size() == 0) begin
            report_mismatch($sformatf("response %0d:%0d:%0d %0d/%0d/%0d with none pending",
                                      got.now_hour, got.now_minute, got.now_second,
                                      got.now_month, got.now_day, got.now_year));
         end else begin
            want = pending_times.pop_front();
            if (got.now_second !== want.now_second)
               report_mismatch($sformatf("second %0d, want %0d",
                                         got.now_second, want.now_second));
            if (got.now_minute !== want.now_minute)
               report_mismatch($sformatf("minute %0d, want %0d",
                                         got.now_minute, want.now_minute));
            if (got.now_hour !== want.now_hour)
               report_mismatch($sformatf("hour %0d, want %0d",
                                         got.now_hour, want.now_hour));
            if (got.now_day !== want.now_day)
               report_mismatch($sformatf("day %0d, want %0d",
                                         got.now_day, want.now_day));
            if (got.now_month !== want.now_month)
               report_mismatch($sformatf("month %0d, want %0d",
                                         got.now_month, want.now_month));
            if (got.now_year !== want.now_year)
               report_mismatch($sformatf("year %0d, want %0d",
                                         got.now_year, want.now_year));
         end
      end
   end

   // A correct run needs well under two milliseconds even when every word
   // meets the longest gap and the longest stall.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.word = '0;
      rsp_chan.ready = 1'b0;
      calendar_now.now_second = '0;
      calendar_now.now_minute = '0;
      calendar_now.now_hour   = '0;
      calendar_now.now_day    = 5'd1;
      calendar_now.now_month  = 4'd1;
      calendar_now.now_year   = YEAR_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_edges();
      test_drain_pause();
      test_random_calendar();

      // After the drain the bench keeps watching the response channel, so that
      // any stray response word is caught.
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/ccst_pkg.sv
sv/ccst_if.sv
sv/ccst_leap.sv
sv/ccst_step.sv
sv/calendar_clock_second_tick.sv
sim/calendar_clock_second_tick_tb.sv
